// File: rtl/phit_pkg.sv
// Shared types, constants and helpers for the polygon hit test block.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package phit_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  localparam int COORD_W   = 16;
  localparam int DIFF_W    = 17;
  localparam int MUL_W     = 34;
  localparam int PROD_W    = 68;
  localparam int ACC_W     = 70;
  localparam int SQ_W      = 35;
  localparam int RAD_W     = 12;
  localparam int R2_W      = 24;
  localparam int LO_W      = 18;
  localparam int AC_W      = 32;
  localparam int C2_W      = 64;
  localparam int OUT_IDX_W = 6;

  // Input commands.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Hit kinds.
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_VERTEX   = 2'd1;
  localparam logic [1:0] KIND_EDGE     = 2'd2;
  localparam logic [1:0] KIND_INTERIOR = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_VR = 1'b0;
  localparam logic CFG_ER = 1'b1;

  // Datapath operations.
  localparam logic [4:0] OP_NOP   = 5'd0;
  localparam logic [4:0] OP_SQ_VR = 5'd1;
  localparam logic [4:0] OP_SQ_ER = 5'd2;
  localparam logic [4:0] OP_SHIFT = 5'd3;
  localparam logic [4:0] OP_VDIFF = 5'd4;
  localparam logic [4:0] OP_EDIFF = 5'd5;
  localparam logic [4:0] OP_M_WW  = 5'd6;
  localparam logic [4:0] OP_A_WW  = 5'd7;
  localparam logic [4:0] OP_M_DD  = 5'd8;
  localparam logic [4:0] OP_A_DD  = 5'd9;
  localparam logic [4:0] OP_M_QD  = 5'd10;
  localparam logic [4:0] OP_A_QD  = 5'd11;
  localparam logic [4:0] OP_M_QQ  = 5'd12;
  localparam logic [4:0] OP_A_QQ  = 5'd13;
  localparam logic [4:0] OP_M_CR  = 5'd14;
  localparam logic [4:0] OP_S_CR  = 5'd15;
  localparam logic [4:0] OP_M_RC  = 5'd16;
  localparam logic [4:0] OP_S_RC  = 5'd17;
  localparam logic [4:0] OP_M_AC  = 5'd18;
  localparam logic [4:0] OP_M_RL  = 5'd19;
  localparam logic [4:0] OP_A_RH  = 5'd20;

  // Accumulator save targets.
  localparam logic [3:0] SV_NONE  = 4'd0;
  localparam logic [3:0] SV_VR2   = 4'd1;
  localparam logic [3:0] SV_ER2   = 4'd2;
  localparam logic [3:0] SV_DEN   = 4'd3;
  localparam logic [3:0] SV_NUM   = 4'd4;
  localparam logic [3:0] SV_DQ    = 4'd5;
  localparam logic [3:0] SV_DB    = 4'd6;
  localparam logic [3:0] SV_CROSS = 4'd7;
  localparam logic [3:0] SV_C2    = 4'd8;

  typedef struct packed {
    logic [4:0]       op;
    logic [3:0]       save;
    logic             latch;
    logic             wr_en;
    logic [IDX_W-1:0] addr;
  } phit_cmd_t;

  typedef struct packed {
    logic vert_near;
    logic edge_short;
    logic edge_near_short;
    logic long_near;
    logic cross_toggle;
  } phit_stat_t;

  typedef struct packed {
    logic                 found;
    logic [1:0]           kind;
    logic [OUT_IDX_W-1:0] vidx;
    logic [OUT_IDX_W-1:0] es;
    logic [OUT_IDX_W-1:0] ee;
    logic                 ovf;
  } phit_res_t;

  function automatic logic [OUT_IDX_W-1:0] fit_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W+OUT_IDX_W-1:0] w;
    w = {{OUT_IDX_W{1'b0}}, idx};
    return w[OUT_IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/phit_dp.sv
// Datapath of the polygon hit test: vertex memory, coordinate registers,
// one shared multiply-accumulate unit and the distance compares. Uses phit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module phit_dp import phit_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [RAD_W-1:0]          cfg_data,
  input  wire logic signed [COORD_W-1:0] pt_x,
  input  wire logic signed [COORD_W-1:0] pt_y,
  input  wire phit_cmd_t                 cmd,
  output phit_stat_t                     stat
);

  localparam logic [2:0] M_HOLD  = 3'd0;
  localparam logic [2:0] M_LOAD  = 3'd1;
  localparam logic [2:0] M_ADD   = 3'd2;
  localparam logic [2:0] M_SUB   = 3'd3;
  localparam logic [2:0] M_ADDSH = 3'd4;

  logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];
  logic signed [COORD_W-1:0] rd_x_r, rd_y_r;

  logic [RAD_W-1:0] vr_r, er_r;
  logic signed [COORD_W-1:0] px_r, py_r, ax_r, ay_r, bx_r, by_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, qx_r, qy_r, wx_r, wy_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [R2_W-1:0] vr2_r, er2_r;
  logic [SQ_W-1:0] den_r, num_r, dq_r, db_r;
  logic [AC_W-1:0] ac_r;
  logic            big_r;
  logic [C2_W-1:0] c2_r;

  logic signed [MUL_W-1:0]  ma, mb;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_x;
  logic [2:0]               mode;
  logic signed [ACC_W-1:0]  acc_abs;

  function automatic logic signed [DIFF_W-1:0] sub16(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
    return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
  endfunction

  function automatic logic signed [MUL_W-1:0] sx(input logic signed [DIFF_W-1:0] d);
    return $signed({{(MUL_W-DIFF_W){d[DIFF_W-1]}}, d});
  endfunction

  always_comb begin
    ma   = '0;
    mb   = '0;
    mode = M_HOLD;
    case (cmd.op)
      OP_SQ_VR: begin
        ma = $signed({{(MUL_W-RAD_W){1'b0}}, vr_r}); mb = ma; mode = M_LOAD;
      end
      OP_SQ_ER: begin
        ma = $signed({{(MUL_W-RAD_W){1'b0}}, er_r}); mb = ma; mode = M_LOAD;
      end
      OP_M_WW: begin ma = sx(wx_r); mb = sx(wx_r); mode = M_LOAD; end
      OP_A_WW: begin ma = sx(wy_r); mb = sx(wy_r); mode = M_ADD;  end
      OP_M_DD: begin ma = sx(dx_r); mb = sx(dx_r); mode = M_LOAD; end
      OP_A_DD: begin ma = sx(dy_r); mb = sx(dy_r); mode = M_ADD;  end
      OP_M_QD: begin ma = sx(qx_r); mb = sx(dx_r); mode = M_LOAD; end
      OP_A_QD: begin ma = sx(qy_r); mb = sx(dy_r); mode = M_ADD;  end
      OP_M_QQ: begin ma = sx(qx_r); mb = sx(qx_r); mode = M_LOAD; end
      OP_A_QQ: begin ma = sx(qy_r); mb = sx(qy_r); mode = M_ADD;  end
      OP_M_CR: begin ma = sx(qx_r); mb = sx(dy_r); mode = M_LOAD; end
      OP_S_CR: begin ma = sx(qy_r); mb = sx(dx_r); mode = M_SUB;  end
      OP_M_RC: begin ma = sx(dx_r); mb = sx(wy_r); mode = M_LOAD; end
      OP_S_RC: begin ma = sx(wx_r); mb = sx(dy_r); mode = M_SUB;  end
      OP_M_AC: begin
        ma = $signed({{(MUL_W-AC_W){1'b0}}, ac_r}); mb = ma; mode = M_LOAD;
      end
      OP_M_RL: begin
        ma = $signed({{(MUL_W-R2_W){1'b0}}, er2_r});
        mb = $signed({{(MUL_W-LO_W){1'b0}}, den_r[LO_W-1:0]});
        mode = M_LOAD;
      end
      OP_A_RH: begin
        ma = $signed({{(MUL_W-R2_W){1'b0}}, er2_r});
        mb = $signed({{(MUL_W-SQ_W+LO_W){1'b0}}, den_r[SQ_W-1:LO_W]});
        mode = M_ADDSH;
      end
      default: ;
    endcase
  end

  assign prod   = ma * mb;
  assign prod_x = $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});

  always_comb begin
    case (mode)
      M_LOAD:  acc_nxt = prod_x;
      M_ADD:   acc_nxt = acc_r + prod_x;
      M_SUB:   acc_nxt = acc_r - prod_x;
      M_ADDSH: acc_nxt = acc_r + (prod_x <<< LO_W);
      default: acc_nxt = acc_r;
    endcase
  end

  assign acc_abs = acc_r[ACC_W-1] ? -acc_r : acc_r;

  // Vertex memory, written by appends and read one entry a cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_x[cmd.addr] <= pt_x;
      mem_y[cmd.addr] <= pt_y;
    end
    rd_x_r <= mem_x[cmd.addr];
    rd_y_r <= mem_y[cmd.addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vr_r <= RAD_W'(160);
      er_r <= RAD_W'(192);
    end else if (cfg_we) begin
      if (cfg_index == CFG_VR) vr_r <= cfg_data;
      if (cfg_index == CFG_ER) er_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.latch) begin
      px_r <= pt_x;
      py_r <= pt_y;
    end
    case (cmd.op)
      OP_SHIFT: begin
        ax_r <= bx_r;
        ay_r <= by_r;
        bx_r <= rd_x_r;
        by_r <= rd_y_r;
      end
      OP_VDIFF: begin
        wx_r <= sub16(px_r, bx_r);
        wy_r <= sub16(py_r, by_r);
      end
      OP_EDIFF: begin
        dx_r <= sub16(bx_r, ax_r);
        dy_r <= sub16(by_r, ay_r);
        qx_r <= sub16(px_r, ax_r);
        qy_r <= sub16(py_r, ay_r);
        wx_r <= sub16(px_r, bx_r);
        wy_r <= sub16(py_r, by_r);
      end
      default: ;
    endcase
    case (cmd.save)
      SV_VR2: vr2_r <= acc_r[R2_W-1:0];
      SV_ER2: er2_r <= acc_r[R2_W-1:0];
      SV_DEN: den_r <= acc_r[SQ_W-1:0];
      SV_NUM: num_r <= acc_r[SQ_W-1:0];
      SV_DQ:  dq_r  <= acc_r[SQ_W-1:0];
      SV_DB:  db_r  <= acc_r[SQ_W-1:0];
      SV_CROSS: begin
        ac_r  <= acc_abs[AC_W-1:0];
        big_r <= |acc_abs[ACC_W-1:AC_W];
      end
      SV_C2:  c2_r  <= acc_r[C2_W-1:0];
      default: ;
    endcase
  end

  logic den_zero, num_nonpos, num_ge;
  logic [SQ_W-1:0] er2_w;

  assign er2_w      = {{(SQ_W-R2_W){1'b0}}, er2_r};
  assign den_zero   = (den_r == '0);
  assign num_nonpos = num_r[SQ_W-1] || (num_r == '0);
  assign num_ge     = !num_nonpos && (num_r >= den_r);

  assign stat.vert_near       = (acc_r <= $signed({{(ACC_W-R2_W){1'b0}}, vr2_r}));
  assign stat.edge_short      = den_zero || num_nonpos || num_ge || big_r;
  assign stat.edge_near_short = (den_zero || num_nonpos) ? (dq_r <= er2_w) :
                                num_ge ? (db_r <= er2_w) : 1'b0;
  assign stat.long_near       = (c2_r <= acc_r[C2_W-1:0]);
  assign stat.cross_toggle    = ((by_r > py_r) != (ay_r > py_r)) &&
                                (dy_r[DIFF_W-1] ? acc_r[ACC_W-1] :
                                 (!acc_r[ACC_W-1] && (acc_r != '0)));

endmodule

`default_nettype wire

// File: rtl/phit_ctrl.sv
// Controller of the polygon hit test: command decode, vertex count, the
// query sequencer and the result register. Uses phit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module phit_ctrl import phit_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [1:0] in_cmd,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output phit_res_t       res,
  output phit_cmd_t       cmd,
  input  wire phit_stat_t stat
);

  localparam logic [5:0] ST_IDLE = 6'd0;
  localparam logic [5:0] ST_R0   = 6'd1;
  localparam logic [5:0] ST_R1   = 6'd2;
  localparam logic [5:0] ST_R2   = 6'd3;
  localparam logic [5:0] ST_V_RD = 6'd4;
  localparam logic [5:0] ST_V_LD = 6'd5;
  localparam logic [5:0] ST_V_DF = 6'd6;
  localparam logic [5:0] ST_V_M1 = 6'd7;
  localparam logic [5:0] ST_V_M2 = 6'd8;
  localparam logic [5:0] ST_V_CK = 6'd9;
  localparam logic [5:0] ST_E_R0 = 6'd10;
  localparam logic [5:0] ST_E_L0 = 6'd11;
  localparam logic [5:0] ST_E_RD = 6'd12;
  localparam logic [5:0] ST_E_LD = 6'd13;
  localparam logic [5:0] ST_E_DF = 6'd14;
  localparam logic [5:0] ST_E1   = 6'd15;
  localparam logic [5:0] ST_E2   = 6'd16;
  localparam logic [5:0] ST_E3   = 6'd17;
  localparam logic [5:0] ST_E4   = 6'd18;
  localparam logic [5:0] ST_E5   = 6'd19;
  localparam logic [5:0] ST_E6   = 6'd20;
  localparam logic [5:0] ST_E7   = 6'd21;
  localparam logic [5:0] ST_E8   = 6'd22;
  localparam logic [5:0] ST_E9   = 6'd23;
  localparam logic [5:0] ST_E10  = 6'd24;
  localparam logic [5:0] ST_E11  = 6'd25;
  localparam logic [5:0] ST_E12  = 6'd26;
  localparam logic [5:0] ST_E_CK = 6'd27;
  localparam logic [5:0] ST_L1   = 6'd28;
  localparam logic [5:0] ST_L2   = 6'd29;
  localparam logic [5:0] ST_L3   = 6'd30;
  localparam logic [5:0] ST_L4   = 6'd31;
  localparam logic [5:0] ST_FIN  = 6'd32;

  logic [5:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, k_r, k_nxt, k_calc;
  logic             par_r, par_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic             out_valid_r, out_valid_nxt;
  phit_res_t        res_r, res_nxt;
  logic             accept, last, par_now;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign last       = ((CNT_W'(i_r) + CNT_W'(1)) == count_r);
  assign k_calc     = last ? '0 : i_r + IDX_W'(1);
  assign out_tvalid = out_valid_r;
  assign res        = res_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    par_nxt       = par_r;
    kind_nxt      = kind_r;
    res_nxt       = res_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    par_now       = par_r;
    cmd           = '0;
    cmd.op        = OP_NOP;
    cmd.save      = SV_NONE;
    case (state_r)
      ST_IDLE: begin
        cmd.addr = count_r[IDX_W-1:0];
        if (accept) begin
          case (in_cmd)
            CMD_CLEAR: begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            CMD_APPEND: begin
              if (count_r < CNT_W'(MAX_VERTICES)) begin
                cmd.wr_en = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_QUERY: begin
              cmd.latch = 1'b1;
              i_nxt     = '0;
              k_nxt     = '0;
              par_nxt   = 1'b0;
              kind_nxt  = KIND_NONE;
              state_nxt = (count_r == '0) ? ST_FIN : ST_R0;
            end
            default: ;
          endcase
        end
      end
      ST_R0: begin cmd.op = OP_SQ_VR; state_nxt = ST_R1; end
      ST_R1: begin cmd.op = OP_SQ_ER; cmd.save = SV_VR2; state_nxt = ST_R2; end
      ST_R2: begin cmd.save = SV_ER2; state_nxt = ST_V_RD; end
      ST_V_RD: begin cmd.addr = i_r; state_nxt = ST_V_LD; end
      ST_V_LD: begin cmd.op = OP_SHIFT; state_nxt = ST_V_DF; end
      ST_V_DF: begin cmd.op = OP_VDIFF; state_nxt = ST_V_M1; end
      ST_V_M1: begin cmd.op = OP_M_WW; state_nxt = ST_V_M2; end
      ST_V_M2: begin cmd.op = OP_A_WW; state_nxt = ST_V_CK; end
      ST_V_CK: begin
        if (stat.vert_near) begin
          kind_nxt  = KIND_VERTEX;
          state_nxt = ST_FIN;
        end else if (last) begin
          i_nxt     = '0;
          state_nxt = ST_E_R0;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = ST_V_RD;
        end
      end
      ST_E_R0: begin cmd.addr = '0; state_nxt = ST_E_L0; end
      ST_E_L0: begin cmd.op = OP_SHIFT; state_nxt = ST_E_RD; end
      ST_E_RD: begin cmd.addr = k_calc; k_nxt = k_calc; state_nxt = ST_E_LD; end
      ST_E_LD: begin cmd.op = OP_SHIFT; state_nxt = ST_E_DF; end
      ST_E_DF: begin cmd.op = OP_EDIFF; state_nxt = ST_E1; end
      ST_E1:  begin cmd.op = OP_M_DD; state_nxt = ST_E2; end
      ST_E2:  begin cmd.op = OP_A_DD; state_nxt = ST_E3; end
      ST_E3:  begin cmd.op = OP_M_QD; cmd.save = SV_DEN; state_nxt = ST_E4; end
      ST_E4:  begin cmd.op = OP_A_QD; state_nxt = ST_E5; end
      ST_E5:  begin cmd.op = OP_M_QQ; cmd.save = SV_NUM; state_nxt = ST_E6; end
      ST_E6:  begin cmd.op = OP_A_QQ; state_nxt = ST_E7; end
      ST_E7:  begin cmd.op = OP_M_WW; cmd.save = SV_DQ; state_nxt = ST_E8; end
      ST_E8:  begin cmd.op = OP_A_WW; state_nxt = ST_E9; end
      ST_E9:  begin cmd.op = OP_M_CR; cmd.save = SV_DB; state_nxt = ST_E10; end
      ST_E10: begin cmd.op = OP_S_CR; state_nxt = ST_E11; end
      ST_E11: begin cmd.op = OP_M_RC; cmd.save = SV_CROSS; state_nxt = ST_E12; end
      ST_E12: begin cmd.op = OP_S_RC; state_nxt = ST_E_CK; end
      ST_E_CK: begin
        par_now = par_r ^ stat.cross_toggle;
        par_nxt = par_now;
        if (!stat.edge_short) begin
          state_nxt = ST_L1;
        end else if (stat.edge_near_short) begin
          kind_nxt  = KIND_EDGE;
          state_nxt = ST_FIN;
        end else if (last) begin
          kind_nxt  = (count_r >= CNT_W'(3) && par_now) ? KIND_INTERIOR : KIND_NONE;
          state_nxt = ST_FIN;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = ST_E_RD;
        end
      end
      ST_L1: begin cmd.op = OP_M_AC; state_nxt = ST_L2; end
      ST_L2: begin cmd.op = OP_M_RL; cmd.save = SV_C2; state_nxt = ST_L3; end
      ST_L3: begin cmd.op = OP_A_RH; state_nxt = ST_L4; end
      ST_L4: begin
        if (stat.long_near) begin
          kind_nxt  = KIND_EDGE;
          state_nxt = ST_FIN;
        end else if (last) begin
          kind_nxt  = (count_r >= CNT_W'(3) && par_r) ? KIND_INTERIOR : KIND_NONE;
          state_nxt = ST_FIN;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = ST_E_RD;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          res_nxt.found = (kind_r != KIND_NONE);
          res_nxt.kind  = kind_r;
          res_nxt.vidx  = (kind_r == KIND_VERTEX) ? fit_idx(i_r) : '0;
          res_nxt.es    = (kind_r == KIND_EDGE) ? fit_idx(i_r) : '0;
          res_nxt.ee    = (kind_r == KIND_EDGE) ? fit_idx(k_r) : '0;
          res_nxt.ovf   = ovf_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    par_r  <= par_nxt;
    kind_r <= kind_nxt;
    res_r  <= res_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/polygon_hit_test_top.sv
// Top level of the polygon hit test block: stream ports and the config port.
// Instantiates phit_ctrl and phit_dp; uses phit_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a polygon of up to MAX_VERTICES vertices in an internal
// memory and answers hit queries against it. Each input beat carries a
// command in in_tuser: a clear empties the polygon and the overflow flag, an
// append adds the point as the next vertex (an append to a full polygon is
// dropped and sets the sticky overflow flag), and a query produces exactly
// one result beat. A query first looks for the lowest-index vertex within
// the vertex radius, then for the first ring edge within the edge radius,
// and finally runs an even-odd ray cast for the interior; polygons with
// fewer than three vertices never report an interior hit. Clear and append
// never drop in_tready. A query is accepted, runs its setup, scans each
// vertex, starts the edge walk and scans each edge, adding the full
// squared-distance compare when the point projects onto the inside of
// the edge, then posts the result. Its run time is set by the single shared
// multiply-accumulate unit, which does every product one after the other,
// and by the one read port of the vertex memory. The result sits in an
// output register, so a new item is taken while it waits; a following query
// holds in its final cycle until the earlier result is taken. The user must
// write the radii through the cfg port only while the block is idle; the
// block itself does not enforce this.
module polygon_hit_test_top import phit_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // point_x [15:0], point_y [31:16]
  input  wire logic [1:0]  in_tuser,  // command [1:0]
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // found [0], vertex_index [6:1],
                                      // edge_start [12:7], edge_end [18:13],
                                      // overflowed [19], zero [23:20]
  output logic [1:0]       out_tuser, // hit_kind [1:0]
  // Configuration writes: index 0 vertex_radius, index 1 edge_radius.
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [RAD_W-1:0] cfg_data
);

  phit_cmd_t  cmd;
  phit_stat_t stat;
  phit_res_t  res;

  // The controller owns the vertex count, the sequencing and the result.
  phit_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res        (res),
    .cmd        (cmd),
    .stat       (stat)
  );

  // The datapath holds the vertices, the radii and the arithmetic.
  phit_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pt_x      ($signed(in_tdata[15:0])),
    .pt_y      ($signed(in_tdata[31:16])),
    .cmd       (cmd),
    .stat      (stat)
  );

  assign out_tdata = {4'b0000, res.ovf, res.ee, res.es, res.vidx, res.found};
  assign out_tuser = res.kind;

endmodule

`default_nettype wire

// File: rtl/phit_chk.sv
// Port-level checker for the polygon hit test, bound to the top level.
// Uses phit_pkg for the hit kind codes.
`timescale 1ns / 1ps
`default_nettype none

module phit_chk import phit_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // The found flag agrees with the hit kind.
  a_found_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tuser != KIND_NONE)))
    else $error("found flag disagrees with hit kind");

  // Only a vertex hit carries a vertex index.
  a_vidx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_VERTEX) |-> (out_tdata[6:1] == 6'd0))
    else $error("vertex index set without a vertex hit");

  // Only an edge hit carries edge indexes.
  a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_EDGE) |->
      (out_tdata[12:7] == 6'd0 && out_tdata[18:13] == 6'd0))
    else $error("edge indexes set without an edge hit");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result beat changed");

endmodule

bind polygon_hit_test_top phit_chk u_phit_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
